### hw/rtl/npc_pkg.sv
package npc_pkg;

  localparam int MAX_PACKET_BYTES = 512;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int START_W          = $clog2(MAX_PACKET_BYTES + 256);
  localparam int DESC_SLOTS       = 16;
  localparam int DESC_COUNT_W     = 5;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int MIN_PACKET_BYTES = 6;
  localparam int FIELD_START      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_DESCRIPTOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_DESC_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_DESC_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_DESC_CNT  = 3'd5;

  localparam logic [7:0] SYNC_FIRST_RST     = 8'd117;
  localparam logic [7:0] SYNC_SECOND_RST    = 8'd101;
  localparam logic [7:0] SET_DESCRIPTOR_RST = 8'd130;

  localparam logic PHASE_LEN  = 1'b0;
  localparam logic PHASE_DESC = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HEADER   = 3'd2,
    ST_CHECK    = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_ZERO_LEN = 3'd5,
    ST_CUT      = 3'd6
  } npc_status_e;

  typedef struct packed {
    logic [7:0]                   sync_first;
    logic [7:0]                   sync_second;
    logic [7:0]                   set_descriptor;
    logic [DESC_SLOTS-1:0][7:0]   desc_table;
    logic [DESC_COUNT_W-1:0]      desc_count;
  } npc_cfg_t;

  typedef struct packed {
    npc_status_e status;
    logic [7:0]  field_count;
    logic [15:0] computed_check;
  } npc_result_t;

endpackage

### hw/rtl/npc_cfg_regs.sv
module npc_cfg_regs
  import npc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output npc_cfg_t              cfg_o
);

  logic [7:0]              sync_first_q;
  logic [7:0]              sync_second_q;
  logic [7:0]              set_desc_q;
  logic [63:0]             desc_low_q;
  logic [63:0]             desc_high_q;
  logic [DESC_COUNT_W-1:0] desc_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      set_desc_q    <= SET_DESCRIPTOR_RST;
      desc_low_q    <= '0;
      desc_high_q   <= '0;
      desc_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST:      sync_first_q  <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND:     sync_second_q <= cfg_wdata_i[7:0];
        CFG_SET_DESCRIPTOR:  set_desc_q    <= cfg_wdata_i[7:0];
        CFG_KNOWN_DESC_LOW:  desc_low_q    <= cfg_wdata_i[63:0];
        CFG_KNOWN_DESC_HIGH: desc_high_q   <= cfg_wdata_i[63:0];
        CFG_KNOWN_DESC_CNT:  desc_count_q  <= cfg_wdata_i[DESC_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.sync_first     = sync_first_q;
  assign cfg_o.sync_second    = sync_second_q;
  assign cfg_o.set_descriptor = set_desc_q;
  assign cfg_o.desc_table     = {desc_high_q, desc_low_q};
  assign cfg_o.desc_count     = desc_count_q;

endmodule

### hw/rtl/npc_walk.sv
module npc_walk
  import npc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  npc_cfg_t    cfg_i,
  output npc_result_t result_o
);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         held0_q, held1_q;
  logic [7:0]         sf_q, sf_d;
  logic [7:0]         ss_q, ss_d;
  logic [START_W-1:0] nfs_q, nfs_d;
  logic               phase_q, phase_d;
  npc_status_e        err_q, err_d;
  logic [7:0]         fields_q, fields_d;

  logic               overlong;
  logic               take;
  logic [POS_W-1:0]   idx;
  logic [7:0]         b;
  logic               known;
  logic [15:0]        received;
  npc_status_e        status;

  always_comb begin
    overlong = pos_q >= POS_W'(MAX_PACKET_BYTES);
    take     = pos_q >= POS_W'(2);
    idx      = pos_q - POS_W'(2);
    b        = held0_q;

    sf_d = take ? sf_q + b : sf_q;
    ss_d = take ? ss_q + sf_d : ss_q;

    known = 1'b0;
    for (int k = 0; k < DESC_SLOTS; k++) begin
      if ((DESC_COUNT_W'(k) < cfg_i.desc_count) && (cfg_i.desc_table[k] == b)) begin
        known = 1'b1;
      end
    end

    err_d    = err_q;
    phase_d  = phase_q;
    nfs_d    = nfs_q;
    fields_d = fields_q;
    if (take && !overlong && (err_q == ST_OK)) begin
      if (idx == POS_W'(0)) begin
        if (b != cfg_i.sync_first) err_d = ST_HEADER;
      end else if (idx == POS_W'(1)) begin
        if (b != cfg_i.sync_second) err_d = ST_HEADER;
      end else if (idx == POS_W'(2)) begin
        if (b != cfg_i.set_descriptor) err_d = ST_HEADER;
      end else if (idx >= POS_W'(FIELD_START)) begin
        if (phase_q == PHASE_DESC) begin
          if (fields_q != 8'hFF) fields_d = fields_q + 8'd1;
          if (!known) begin
            err_d = ST_UNKNOWN;
          end else begin
            phase_d = PHASE_LEN;
          end
        end
        if ((err_d == ST_OK) && (phase_d == PHASE_LEN) && (START_W'(idx) == nfs_q)) begin
          if (b == 8'd0) begin
            err_d = ST_ZERO_LEN;
          end else begin
            nfs_d   = START_W'(idx) + START_W'(b);
            phase_d = PHASE_DESC;
          end
        end
      end
    end

    pos_d    = overlong ? pos_q : pos_q + POS_W'(1);
    received = {held1_q, data_byte_i};

    if (overlong) begin
      status = ST_HEADER;
    end else if (pos_d < POS_W'(MIN_PACKET_BYTES)) begin
      status = ST_SHORT;
    end else if (err_d == ST_HEADER) begin
      status = ST_HEADER;
    end else if (received != {sf_d, ss_d}) begin
      status = ST_CHECK;
    end else if (err_d != ST_OK) begin
      status = err_d;
    end else if (phase_d == PHASE_DESC) begin
      status = ST_CUT;
    end else begin
      status = ST_OK;
    end
  end

  assign result_o.status         = status;
  assign result_o.field_count    = fields_d;
  assign result_o.computed_check = {sf_d, ss_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      held0_q  <= '0;
      held1_q  <= '0;
      sf_q     <= '0;
      ss_q     <= '0;
      nfs_q    <= START_W'(FIELD_START);
      phase_q  <= PHASE_LEN;
      err_q    <= ST_OK;
      fields_q <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q    <= '0;
        held0_q  <= '0;
        held1_q  <= '0;
        sf_q     <= '0;
        ss_q     <= '0;
        nfs_q    <= START_W'(FIELD_START);
        phase_q  <= PHASE_LEN;
        err_q    <= ST_OK;
        fields_q <= '0;
      end else begin
        pos_q    <= pos_d;
        held0_q  <= held1_q;
        held1_q  <= data_byte_i;
        sf_q     <= sf_d;
        ss_q     <= ss_d;
        nfs_q    <= nfs_d;
        phase_q  <= phase_d;
        err_q    <= err_d;
        fields_q <= fields_d;
      end
    end
  end

endmodule

### hw/rtl/nav_packet_checker.sv
// Channel  | Handshake               | Payload
// input    | in_valid_i, in_stall_o  | data_byte_i, last_byte_i
// output   | out_valid_o, out_stall_i| status_o, field_count_o, computed_check_o
// config   | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One byte is taken per cycle unless in_stall_o holds it; the byte register feeds the
// packet state and the result register, which captures the status of the final byte.
// Reset clears the packet state and loads the register defaults.
// A stalled result holds the output register, and only a final byte then waits
// in the byte register; other bytes keep flowing.
module nav_packet_checker
  import npc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [7:0]            field_count_o,
  output logic [15:0]           computed_check_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  npc_cfg_t    cfg;
  npc_result_t res;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        out_valid_q, out_valid_d;
  npc_result_t out_res_q;

  logic        out_free;
  logic        s1_go;
  logic        accept;

  npc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  npc_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_go),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg),
    .result_o    (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_go && s1_last_q) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign field_count_o    = out_res_q.field_count;
  assign computed_check_o = out_res_q.computed_check;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import npc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  last_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            status_o;
  logic [7:0]            field_count_o;
  logic [15:0]           computed_check_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  nav_packet_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .field_count_o    (field_count_o),
    .computed_check_o (computed_check_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Register mirror and packet state of the checker as the testbench sees it.
  npc_cfg_t    regs;
  int          byte_pos;
  logic [7:0]  held [2];
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  int          field_at;
  bit          desc_due;
  npc_status_e walk_err;
  logic [7:0]  headers_seen;

  npc_result_t awaited_reports [$];
  logic [7:0]  frame [$];

  int errors = 0;
  int packets_sent = 0;
  int bytes_sent = 0;
  int reg_writes = 0;
  int status_hits [8];
  bit idle_enable = 1'b0;
  int run_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  function automatic bit desc_listed(logic [7:0] d);
    int n;
    n = (regs.desc_count > DESC_SLOTS) ? DESC_SLOTS : int'(regs.desc_count);
    for (int k = 0; k < n; k++) begin
      if (regs.desc_table[k] == d) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_packet();
    byte_pos     = 0;
    held[0]      = '0;
    held[1]      = '0;
    sum_a        = '0;
    sum_b        = '0;
    field_at     = FIELD_START;
    desc_due     = 1'b0;
    walk_err     = ST_OK;
    headers_seen = '0;
  endfunction

  function automatic void take_byte(int idx, logic [7:0] b, bit walk);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
    if (!walk || walk_err != ST_OK) return;
    if ((idx == 0 && b != regs.sync_first) || (idx == 1 && b != regs.sync_second) ||
        (idx == 2 && b != regs.set_descriptor)) begin
      walk_err = ST_HEADER;
      return;
    end
    if (idx < FIELD_START) return;
    if (desc_due) begin
      if (headers_seen != 8'hFF) headers_seen++;
      if (!desc_listed(b)) begin
        walk_err = ST_UNKNOWN;
        return;
      end
      desc_due = 1'b0;
    end
    if (!desc_due && idx == field_at) begin
      if (b == 8'h00) begin
        walk_err = ST_ZERO_LEN;
        return;
      end
      field_at = idx + int'(b);
      desc_due = 1'b1;
    end
  endfunction

  function automatic void track_byte(logic [7:0] b, logic fin);
    bit          overlong;
    logic [15:0] received;
    npc_result_t r;
    overlong = (byte_pos >= MAX_PACKET_BYTES);
    if (byte_pos >= 2) take_byte(byte_pos - 2, held[0], !overlong);
    held[0] = held[1];
    held[1] = b;
    if (!overlong) byte_pos++;
    if (fin) begin
      received = {held[0], b};
      r.computed_check = {sum_a, sum_b};
      r.field_count    = headers_seen;
      if (overlong) r.status = ST_HEADER;
      else if (byte_pos < MIN_PACKET_BYTES) r.status = ST_SHORT;
      else if (walk_err == ST_HEADER) r.status = ST_HEADER;
      else if (received != r.computed_check) r.status = ST_CHECK;
      else if (walk_err != ST_OK) r.status = walk_err;
      else if (desc_due) r.status = ST_CUT;
      else r.status = ST_OK;
      awaited_reports.push_back(r);
      clear_packet();
    end
  endfunction

  always @(posedge clk_i) begin
    npc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        $error("status item arrived with none awaited");
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        status_hits[want.status]++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (field_count_o !== want.field_count) begin
          $error("field_count: expected %0d, got %0d", want.field_count, field_count_o);
          errors++;
        end
        if (computed_check_o !== want.computed_check) begin
          $error("computed_check: expected %h, got %h", want.computed_check,
                 computed_check_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!idle_enable) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 7) != 0);
        default: out_stall_i <= ((mode_left % 8) < 3);
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    int pause;
    if (idle_enable && run_left == 0) begin
      pause    = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      run_left = $urandom_range(1, 24);
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    if (run_left > 0) run_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    packets_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_SYNC_FIRST:      regs.sync_first = value[7:0];
      CFG_SYNC_SECOND:     regs.sync_second = value[7:0];
      CFG_SET_DESCRIPTOR:  regs.set_descriptor = value[7:0];
      CFG_KNOWN_DESC_LOW:  regs.desc_table[7:0] = value;
      CFG_KNOWN_DESC_HIGH: regs.desc_table[15:8] = value;
      CFG_KNOWN_DESC_CNT:  regs.desc_count = value[DESC_COUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] known_desc();
    int n;
    n = (regs.desc_count > DESC_SLOTS) ? DESC_SLOTS : int'(regs.desc_count);
    if (n == 0) return 8'($urandom);
    return regs.desc_table[$urandom_range(0, n - 1)];
  endfunction

  function automatic logic [7:0] unknown_desc();
    logic [7:0] d;
    do d = 8'($urandom); while (desc_listed(d));
    return d;
  endfunction

  function automatic void start_frame();
    frame.delete();
    frame.push_back(regs.sync_first);
    frame.push_back(regs.sync_second);
    frame.push_back(regs.set_descriptor);
    frame.push_back(8'($urandom));
  endfunction

  function automatic void add_field(int len, logic [7:0] d);
    frame.push_back(8'(len));
    frame.push_back(d);
    if (len > 2) repeat (len - 2) frame.push_back(8'($urandom));
  endfunction

  function automatic void add_small_fields();
    int nf;
    nf = (regs.desc_count == 0) ? 0 : $urandom_range(0, 5);
    repeat (nf) add_field($urandom_range(2, 12), known_desc());
  endfunction

  // The payload length must be zero or at least two so the last field closes it exactly.
  function automatic void fill_fields(int payload);
    int rem;
    int len;
    rem = payload;
    while (rem > 0) begin
      if (rem <= 255) len = rem;
      else len = $urandom_range(2, (rem - 2 < 255) ? rem - 2 : 255);
      add_field(len, known_desc());
      rem -= len;
    end
  endfunction

  function automatic void seal_frame(bit good);
    logic [7:0] a;
    logic [7:0] c;
    a = '0;
    c = '0;
    foreach (frame[i]) begin
      a = a + frame[i];
      c = c + a;
    end
    if (!good) begin
      if ($urandom_range(0, 1) != 0) a ^= 8'($urandom_range(1, 255));
      else c ^= 8'($urandom_range(1, 255));
    end
    frame.push_back(a);
    frame.push_back(c);
  endfunction

  task automatic randomize_regs();
    int cnt;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) cnt = 0;
    else if (pick == 1) cnt = $urandom_range(17, 31);
    else cnt = $urandom_range(1, 16);
    write_reg(CFG_SYNC_FIRST, {$urandom, $urandom});
    write_reg(CFG_SYNC_SECOND, {$urandom, $urandom});
    write_reg(CFG_SET_DESCRIPTOR, {$urandom, $urandom});
    write_reg(CFG_KNOWN_DESC_LOW, {$urandom, $urandom});
    write_reg(CFG_KNOWN_DESC_HIGH, {$urandom, $urandom});
    write_reg(CFG_KNOWN_DESC_CNT, {$urandom, 27'($urandom), 5'(cnt)});
  endtask

  task automatic test_reset_values();
    start_frame();
    seal_frame(1'b1);
    send_frame();
    start_frame();
    add_field(2, 8'h00);
    seal_frame(1'b1);
    send_frame();
    settle();
  endtask

  task automatic test_short_packets();
    for (int n = 1; n < MIN_PACKET_BYTES; n++) begin
      frame.delete();
      repeat (n) frame.push_back((n % 2 == 0) ? 8'hFF : 8'($urandom));
      send_frame();
    end
    start_frame();
    seal_frame(1'b0);
    send_frame();
    settle();
  endtask

  task automatic test_header_bytes();
    for (int k = 0; k < 3; k++) begin
      start_frame();
      frame[k] ^= 8'($urandom_range(1, 255));
      seal_frame(1'b1);
      send_frame();
    end
    start_frame();
    frame[1] ^= 8'h80;
    seal_frame(1'b0);
    send_frame();
    settle();
  endtask

  task automatic test_field_walk();
    write_reg(CFG_KNOWN_DESC_LOW, 64'hF0E1D2C3B4A59687);
    write_reg(CFG_KNOWN_DESC_HIGH, 64'h0F1E2D3C4B5A6978);
    write_reg(CFG_KNOWN_DESC_CNT, 64'd16);
    start_frame();
    add_field(2, 8'h87);
    add_field(5, 8'h0F);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    add_field(3, 8'h55);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    add_field(3, 8'h55);
    seal_frame(1'b0);
    send_frame();
    start_frame();
    add_field(2, 8'h87);
    add_field(0, 8'h87);
    seal_frame(1'b1);
    send_frame();
    // A length of one makes the descriptor byte the next length as well.
    start_frame();
    frame.push_back(8'h01);
    add_field(8'h0F, 8'h87);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    add_field(4, 8'h1E);
    frame.push_back(8'h09);
    seal_frame(1'b1);
    send_frame();
    // A field that runs past the checksum is not an error.
    start_frame();
    frame.push_back(8'd40);
    frame.push_back(8'hC3);
    repeat (3) frame.push_back(8'($urandom));
    seal_frame(1'b1);
    send_frame();
    settle();
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_KNOWN_DESC_CNT, (k == 0) ? 64'd31 : (k == 1) ? 64'd15 : 64'd17);
      start_frame();
      add_field(2, 8'h0F);
      seal_frame(1'b1);
      send_frame();
      settle();
    end
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_SYNC_FIRST, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(CFG_SYNC_SECOND, 64'h0);
    write_reg(CFG_SET_DESCRIPTOR, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(CFG_KNOWN_DESC_LOW, '1);
    write_reg(CFG_KNOWN_DESC_HIGH, '0);
    write_reg(CFG_KNOWN_DESC_CNT, 64'd16);
    start_frame();
    add_field(2, 8'hFF);
    add_field(3, 8'h00);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    frame[1] = 8'hFF;
    seal_frame(1'b1);
    send_frame();
    settle();
    write_reg(CFG_SYNC_FIRST, '1);
    write_reg(CFG_SYNC_SECOND, '1);
    write_reg(CFG_SET_DESCRIPTOR, '1);
    write_reg(CFG_KNOWN_DESC_LOW, '0);
    write_reg(CFG_KNOWN_DESC_HIGH, '1);
    write_reg(CFG_KNOWN_DESC_CNT, '0);
    start_frame();
    seal_frame(1'b1);
    send_frame();
    start_frame();
    add_field(2, 8'hFF);
    seal_frame(1'b1);
    send_frame();
    settle();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    start_frame();
    seal_frame(1'b1);
    send_frame();
    settle();
  endtask

  task automatic test_count_saturation();
    write_reg(CFG_KNOWN_DESC_LOW, 64'h01);
    write_reg(CFG_KNOWN_DESC_CNT, 64'd1);
    start_frame();
    repeat (300) frame.push_back(8'h01);
    seal_frame(1'b1);
    send_frame();
    settle();
  endtask

  task automatic test_overlong();
    write_reg(CFG_KNOWN_DESC_LOW, {$urandom, $urandom});
    write_reg(CFG_KNOWN_DESC_CNT, 64'd8);
    start_frame();
    fill_fields(MAX_PACKET_BYTES - 6);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    fill_fields(MAX_PACKET_BYTES - 5);
    seal_frame(1'b1);
    send_frame();
    start_frame();
    fill_fields(MAX_PACKET_BYTES + 82);
    seal_frame(1'b0);
    send_frame();
    settle();
  endtask

  task automatic random_packet();
    int kind;
    int n;
    logic [7:0] d;
    kind = $urandom_range(0, 99);
    start_frame();
    if (kind < 60) begin
      add_small_fields();
      seal_frame(1'b1);
    end else if (kind < 68) begin
      add_small_fields();
      seal_frame(1'b0);
    end else if (kind < 73) begin
      frame[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
      add_small_fields();
      seal_frame(1'b1);
    end else if (kind < 79) begin
      add_small_fields();
      add_field($urandom_range(2, 8), unknown_desc());
      add_small_fields();
      seal_frame(1'b1);
    end else if (kind < 84) begin
      add_small_fields();
      add_field(0, 8'($urandom));
      repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom));
      seal_frame(1'b1);
    end else if (kind < 89) begin
      add_small_fields();
      frame.push_back(8'($urandom_range(1, 255)));
      seal_frame(1'b1);
    end else if (kind < 93) begin
      add_small_fields();
      frame.push_back(8'h01);
      d = known_desc();
      add_field(d, known_desc());
      seal_frame(1'b1);
    end else if (kind < 97) begin
      n = $urandom_range(1, MIN_PACKET_BYTES - 1);
      if ($urandom_range(0, 1) != 0) frame.delete();
      while (frame.size() > n) void'(frame.pop_back());
      while (frame.size() < n) frame.push_back(8'($urandom));
    end else begin
      n = $urandom_range(2, 36);
      repeat (n) frame.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic test_random_traffic();
    int packets;
    int first_byte;
    packets    = 0;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 800) begin
      if (packets % 12 == 0) begin
        settle();
        randomize_regs();
      end
      idle_enable = !(packets >= 24 && packets < 36);
      random_packet();
      packets++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    regs.sync_first     = SYNC_FIRST_RST;
    regs.sync_second    = SYNC_SECOND_RST;
    regs.set_descriptor = SET_DESCRIPTOR_RST;
    regs.desc_table     = '0;
    regs.desc_count     = '0;
    clear_packet();
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_short_packets();
    idle_enable = 1'b1;
    test_header_bytes();
    test_field_walk();
    test_register_extremes();
    test_count_saturation();
    test_overlong();
    test_random_traffic();
    settle();

    $display("Checked %0d packets of %0d bytes in total, with %0d register writes.",
             packets_sent, bytes_sent, reg_writes);
    $display("Outcomes ok/short/header/checksum/unknown/zero/cut: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_hits[ST_OK], status_hits[ST_SHORT], status_hits[ST_HEADER],
             status_hits[ST_CHECK], status_hits[ST_UNKNOWN], status_hits[ST_ZERO_LEN],
             status_hits[ST_CUT]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
